@@ sv/ust_pkg.sv @@
// ---------------------------------------------------------------------------
// ust_pkg
// Shared types and codes for the user session table.
// ---------------------------------------------------------------------------
package ust_pkg;

  localparam logic [1:0] OP_MATCH  = 2'd0;
  localparam logic [1:0] OP_AUTH   = 2'd1;
  localparam logic [1:0] OP_DEAUTH = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_SWEEP   = 2'd2;

  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 24;
  localparam int CNT_W  = 7;

  // one table entry as held in memory (valid bits live in flops)
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic              down;
    logic [TIME_W-1:0] start;
    logic [LIFE_W-1:0] life;
  } entry_t;

endpackage

@@ sv/ust_mem.sv @@
// ---------------------------------------------------------------------------
// ust_mem
// Entry memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module ust_mem import ust_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/user_session_table_with_aging_core.sv @@
// ---------------------------------------------------------------------------
// user_session_table_with_aging_core
// Session table keyed by MAC and IPv4 with up/down state and aging sweeps.
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | sink      | in_valid/in_stall  | op, mac, ip, timeout
//  out     | source    | out_valid/out_stall| status, found, added, full_res, removed
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
//  A request scans the memory one entry a cycle (match, authorize, deauthorize,
//  and ticks that sweep), then goes to the done state, which registers the result
//  word; a tick that does not sweep goes straight to the done state. No new word
//  is taken until the last one has left the done state. The single memory read
//  port sets the scan pace.
//  Reset clears valid bits, clock and control, and loads the countdown and config defaults; no clearing pass.
//  A finished word sits in the output register; the next input word is taken
//  once that register is free or being emptied.
// ---------------------------------------------------------------------------
module user_session_table_with_aging_core import ust_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [MAC_W-1:0]   mac,
  input  logic [IP_W-1:0]    ip,
  input  logic [LIFE_W-1:0]  timeout,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic               found,
  output logic               added,
  output logic               full_res,
  output logic [CNT_W-1:0]   removed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [LIFE_W-1:0]  cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;

  // configuration
  logic              usage_mode;
  logic [LIFE_W-1:0] default_timeout;
  logic [15:0]       sweep_interval;

  logic [TIME_W-1:0] now_seconds;
  logic [15:0]       sweep_countdown;
  logic [ENTRIES-1:0] valid;

  // request held for the scan
  logic [1:0]        r_op;
  logic [MAC_W-1:0]  r_mac;
  logic [IP_W-1:0]   r_ip;
  logic [LIFE_W-1:0] r_life;

  logic [CW-1:0]     rd_cnt;     // next address issued
  logic [AW-1:0]     chk_addr;   // address whose data is on rdata
  logic              chk_vld;
  logic              hit;
  logic [AW-1:0]     hit_addr;
  logic              hit_down;
  logic              hit_fresh;
  logic [TIME_W-1:0] hit_start;
  logic [LIFE_W-1:0] hit_life;
  logic              free_fnd;
  logic [AW-1:0]     free_addr;
  logic [CW-1:0]     rm_cnt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  entry_t            rdata;

  ust_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rdata)
  );

  logic in_acc;
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // per-entry checks on the read data
  logic [TIME_W-1:0] age;
  logic              cur_vld;
  logic              key_eq;
  assign age     = now_seconds - rdata.start;
  assign cur_vld = chk_vld && valid[chk_addr];
  assign key_eq  = cur_vld && rdata.mac == r_mac && rdata.ip == r_ip;

  logic last_chk;
  assign last_chk = chk_vld && ({1'b0, chk_addr} == CW'(ENTRIES - 1));

  // add decision at end of scan
  logic want_add;
  assign want_add = !hit && ((r_op == OP_MATCH && !usage_mode) ||
                             (r_op == OP_AUTH && usage_mode));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_addr;
    mem_wdata = '0;
    mem_wdata.mac   = r_mac;
    mem_wdata.ip    = r_ip;
    mem_wdata.start = now_seconds;
    mem_wdata.life  = r_life;
    if (state == S_DONE && r_op != OP_TICK) begin
      if (hit && r_op != OP_MATCH) begin
        // only the flag changes: rewrite with held fields
        mem_we         = 1'b1;
        mem_wdata.down = (r_op == OP_DEAUTH);
        mem_wdata.start = hit_start;
        mem_wdata.life  = hit_life;
      end else if (want_add && free_fnd) begin
        mem_we    = 1'b1;
        mem_waddr = free_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      usage_mode      <= 1'b0;
      default_timeout <= LIFE_W'(300);
      sweep_interval  <= 16'd60;
      now_seconds     <= '0;
      sweep_countdown <= 16'd60;
      valid           <= '0;
      out_valid       <= 1'b0;
      rd_cnt          <= '0;
      chk_vld         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:    usage_mode      <= cfg_data[0];
          REG_TIMEOUT: default_timeout <= cfg_data;
          REG_SWEEP:   sweep_interval  <= cfg_data[15:0];
          default: ;
        endcase
      end
      // drained word leaves; the done state reloads the register itself
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            r_op      <= op;
            r_mac     <= mac;
            r_ip      <= ip;
            r_life    <= (op == OP_MATCH) ? default_timeout : timeout;
            hit       <= 1'b0;
            free_fnd  <= 1'b0;
            rm_cnt    <= '0;
            rd_cnt    <= '0;
            chk_vld   <= 1'b0;
            if (op == OP_TICK) begin
              now_seconds <= now_seconds + 1'b1;
              if (sweep_countdown <= 16'd1) begin
                sweep_countdown <= sweep_interval;
                state <= S_SCAN;
              end else begin
                sweep_countdown <= sweep_countdown - 1'b1;
                state <= S_DONE;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_cnt != CW'(ENTRIES)) rd_cnt <= rd_cnt + 1'b1;
          chk_vld  <= (rd_cnt != CW'(ENTRIES));
          chk_addr <= rd_cnt[AW-1:0];
          if (chk_vld) begin
            if (r_op == OP_TICK) begin
              if (cur_vld && age > TIME_W'(rdata.life)) begin
                valid[chk_addr] <= 1'b0;
                rm_cnt <= rm_cnt + 1'b1;
              end
            end else begin
              if (key_eq && !hit) begin
                hit       <= 1'b1;
                hit_addr  <= chk_addr;
                hit_down  <= rdata.down;
                hit_fresh <= age < TIME_W'(rdata.life);
                hit_start <= rdata.start;
                hit_life  <= rdata.life;
              end
              if (!valid[chk_addr] && !free_fnd) begin
                free_fnd  <= 1'b1;
                free_addr <= chk_addr;
              end
            end
          end
          if (last_chk) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= 1'b1;
            found     <= 1'b0;
            added     <= 1'b0;
            full_res  <= 1'b0;
            removed   <= '0;
            if (r_op == OP_TICK) begin
              status  <= 1'b0;
              removed <= (rm_cnt > CW'(127)) ? CNT_W'(127) : CNT_W'(rm_cnt);
            end else if (hit) begin
              found <= 1'b1;
              unique case (r_op)
                OP_MATCH: status <= hit_fresh ? hit_down : 1'b1;
                OP_AUTH:  status <= 1'b0;
                default:  status <= 1'b1;
              endcase
            end else if (want_add) begin
              if (free_fnd) begin
                valid[free_addr] <= 1'b1;
                added  <= 1'b1;
                status <= 1'b0;
              end else begin
                full_res <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an input word is never taken outside the idle state
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_acc) else $error("input taken while busy");
  // a result leaves only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("stray result");
  // add and full never together
  a_add_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(added && full_res)) else $error("added with full");

endmodule
